FILE: rtl/tga_rle_packet_decoder_defines.svh
// assertion helpers used by the checker file
`ifndef TGA_RLE_PACKET_DECODER_DEFINES_SVH
`define TGA_RLE_PACKET_DECODER_DEFINES_SVH

// same-cycle implication, inactive during reset
`define TGA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tga rle check failed");

// next-cycle implication, inactive during reset
`define TGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tga rle check failed");

`endif

FILE: rtl/tga_rle_pkg.sv
`default_nettype none
package tga_rle_pkg;

  localparam int unsigned MAX_DIMENSION = 16384;

  localparam int unsigned DIM_W   = 15;
  localparam int unsigned TOTAL_W = 29;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BPP    = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [BPP_W-1:0] BPP_MIN = 3'd2;
  localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [TOTAL_W-1:0] total_t;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tga_rle_packet_decoder.sv
`default_nettype none
// TGA run-length packet decoder. Takes one compressed stream byte per item
// on in_stream_byte: a header (bit 7 = repeat, bits 6:0 = count minus one)
// followed by 2, 3 or 4 little-endian pixel bytes per pixel. A raw packet
// yields one result per pixel with repeat count 1; a repeat packet yields one
// result carrying the pixel and its run, clamped to the pixels left in the
// image. The result that completes width*height pixels has image_done set,
// after which the next byte is read as a header. One byte is taken per clock
// cycle; the whole decode step sits between the state registers and the
// output register, and input stalls only while a finished result is held
// by out_stall, or in the cycle after a configuration write while the
// registered width*height product settles. Headers and partial pixel bytes
// produce no result. cfg_ready is always high.
module tga_rle_packet_decoder import tga_rle_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [DIM_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_stream_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [PIX_W-1:0]         out_pixel_value,
  output logic [CNT_W-1:0]         out_repeat_count,
  output logic                     out_image_done
);

  logic [BPP_W-1:0] bpp_r;
  dim_t             width_r;
  dim_t             height_r;
  total_t           total_r;
  logic             cfg_hold_r;

  logic             hdr_r, hdr_nxt;
  logic             rep_r, rep_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [PIX_W-1:0] asm_r, asm_nxt;
  total_t           dec_r, dec_nxt;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_done_r;

  logic             accept;
  logic             cfg_wr;
  logic             emit;
  logic [CNT_W-1:0] emit_cnt;
  logic             emit_done;
  logic [BPP_W-1:0] eff_bpp;
  logic [CNT_W-1:0] hdr_cnt;
  total_t           remaining;
  total_t           sum;
  logic [PIX_W-1:0] asm_or;
  logic [1:0]       pos_inc;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = cfg_hold_r || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r      <= 3'd3;
      width_r    <= DIM_W'(1);
      height_r   <= DIM_W'(1);
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_index)
          REG_BPP:    bpp_r    <= cfg_data[BPP_W-1:0];
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // product registered; the cycle after a write is covered by cfg_hold_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_W'(1);
    end else begin
      total_r <= TOTAL_W'(clamp_dim(width_r)) * TOTAL_W'(clamp_dim(height_r));
    end
  end

  always_comb begin
    eff_bpp = bpp_r;
    if (bpp_r < BPP_MIN) begin
      eff_bpp = BPP_MIN;
    end else if (bpp_r > BPP_MAX) begin
      eff_bpp = BPP_MAX;
    end
  end

  always_comb begin
    hdr_nxt   = hdr_r;
    rep_nxt   = rep_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    asm_nxt   = asm_r;
    dec_nxt   = dec_r;
    emit      = 1'b0;
    emit_cnt  = CNT_W'(1);
    emit_done = 1'b0;
    hdr_cnt   = {1'b0, in_stream_byte[6:0]} + CNT_W'(1);
    remaining = (dec_r < total_r) ? (total_r - dec_r) : TOTAL_W'(1);
    asm_or    = asm_r | (PIX_W'(in_stream_byte) << {pos_r, 3'b000});
    pos_inc   = pos_r + 2'd1;
    sum       = '0;

    if (hdr_r) begin
      if (TOTAL_W'(hdr_cnt) > remaining) begin
        hdr_cnt = remaining[CNT_W-1:0];
      end
      rep_nxt  = in_stream_byte[7];
      left_nxt = hdr_cnt;
      pos_nxt  = 2'd0;
      asm_nxt  = '0;
      hdr_nxt  = 1'b0;
    end else if (pos_inc != 2'd0 && {1'b0, pos_inc} < eff_bpp) begin
      // pixel still incomplete
      asm_nxt = asm_or;
      pos_nxt = pos_inc;
    end else begin
      emit = 1'b1;
      if (rep_r) begin
        emit_cnt = left_r;
        left_nxt = '0;
      end else begin
        emit_cnt = CNT_W'(1);
        left_nxt = (left_r != '0) ? left_r - CNT_W'(1) : '0;
      end
      sum       = dec_r + TOTAL_W'(emit_cnt);
      emit_done = sum >= total_r;
      dec_nxt   = emit_done ? '0 : sum;
      if (emit_done) begin
        left_nxt = '0;
      end
      asm_nxt = '0;
      pos_nxt = 2'd0;
      hdr_nxt = (left_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= 1'b1;
      rep_r  <= 1'b0;
      left_r <= '0;
      pos_r  <= 2'd0;
      asm_r  <= '0;
      dec_r  <= '0;
    end else if (accept) begin
      hdr_r  <= hdr_nxt;
      rep_r  <= rep_nxt;
      left_r <= left_nxt;
      pos_r  <= pos_nxt;
      asm_r  <= asm_nxt;
      dec_r  <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_pix_r  <= asm_or;
      out_cnt_r  <= emit_cnt;
      out_done_r <= emit_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pix_r;
  assign out_repeat_count = out_cnt_r;
  assign out_image_done   = out_done_r;

endmodule
`default_nettype wire

FILE: rtl/tga_rle_checker.sv
`default_nettype none
`include "tga_rle_packet_decoder_defines.svh"
module tga_rle_checker import tga_rle_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [CNT_W-1:0] out_repeat_count
);

  // a held result keeps its valid
  `TGA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // no new byte while a finished result waits downstream
  `TGA_ASSERT_NOW(a_in_blocked, clk, rst_n, out_valid && out_stall, in_stall)

  // runs are never empty nor longer than a packet
  `TGA_ASSERT_NOW(a_count_range, clk, rst_n, out_valid,
                  out_repeat_count != '0 && out_repeat_count <= CNT_W'(128))

  // input is stalled in the cycle after a register write, while the pixel count product settles
  `TGA_ASSERT_NEXT(a_cfg_settle, clk, rst_n, cfg_valid && cfg_ready, in_stall)

endmodule

bind tga_rle_packet_decoder tga_rle_checker u_tga_rle_checker (.*);
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import tga_rle_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] count;
    logic             done;
  } pixel_result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [IDX_W-1:0] reg_index;
    logic [DIM_W-1:0] data;
    bit               typed;
    pixel_result_t    want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_stream_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_pixel_value;
  logic [CNT_W-1:0] out_repeat_count;
  logic             out_image_done;

  tga_rle_packet_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_image_done   (out_image_done)
  );

  // decoder shadow: registers as written, and the packet / pixel state
  logic [BPP_W-1:0]   set_bpp = 3'd3;
  logic [DIM_W-1:0]   set_width = 15'd1;
  logic [DIM_W-1:0]   set_height = 15'd1;
  bit                 awaiting_header = 1'b1;
  bit                 run_is_repeat = 1'b0;
  logic [CNT_W-1:0]   run_pixels_left = '0;
  logic [1:0]         byte_slot = '0;
  logic [PIX_W-1:0]   pixel_acc = '0;
  logic [TOTAL_W-1:0] image_pixels = '0;

  pixel_result_t expected_pixels[$];
  int            errors = 0;
  bit            quiet = 1'b0;
  int            gap_pct = 20;

  stim_row_t directed_rows [33] = '{
    '{ROW_BYTE, '0, 15'h000, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0ff, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h000, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0aa, 1'b1, '{32'h00aa00ff, 8'd1, 1'b1}},
    '{ROW_CFG, REG_BPP, 15'd4, 1'b0, '0},
    '{ROW_CFG, REG_WIDTH, 15'd0, 1'b0, '0},
    '{ROW_CFG, REG_HEIGHT, 15'd200, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0ff, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h011, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h022, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h033, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h044, 1'b1, '{32'h44332211, 8'd128, 1'b0}},
    '{ROW_BYTE, '0, 15'h0ff, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h000, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h000, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h000, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h080, 1'b1, '{32'h80000000, 8'd72, 1'b1}},
    '{ROW_CFG, REG_BPP, 15'd1, 1'b0, '0},
    '{ROW_CFG, REG_WIDTH, 15'd32767, 1'b0, '0},
    '{ROW_CFG, REG_HEIGHT, 15'd16384, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h001, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0ab, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0cd, 1'b1, '{32'h0000cdab, 8'd1, 1'b0}},
    // widen to 4 bytes, take two, then narrow so the next byte passes the width
    '{ROW_CFG, REG_BPP, 15'd5, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h012, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h034, 1'b0, '0},
    '{ROW_CFG, REG_BPP, 15'd0, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h056, 1'b0, '0},
    // image shrunk below the decoded count
    '{ROW_CFG, REG_WIDTH, 15'd1, 1'b0, '0},
    '{ROW_CFG, REG_HEIGHT, 15'd0, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0ff, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0ee, 1'b0, '0},
    '{ROW_BYTE, '0, 15'h0dd, 1'b1, '{32'h0000ddee, 8'd1, 1'b1}}
  };

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [TOTAL_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return TOTAL_W'(1);
    if (v > DIM_W'(MAX_DIMENSION)) return TOTAL_W'(MAX_DIMENSION);
    return TOTAL_W'(v);
  endfunction

  // advance the shadow decoder by one stream byte; returns 1 when a pixel comes out
  function automatic bit decode_byte(input logic [7:0] b, output pixel_result_t r);
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] remaining;
    logic [CNT_W-1:0]   cnt;
    logic [BPP_W-1:0]   bpp_eff;
    r = '0;
    total = eff_dim(set_width) * eff_dim(set_height);
    if (awaiting_header) begin
      cnt = CNT_W'(b[6:0]) + 8'd1;
      remaining = (image_pixels < total) ? total - image_pixels : TOTAL_W'(1);
      if (TOTAL_W'(cnt) > remaining) cnt = remaining[CNT_W-1:0];
      run_is_repeat = b[7];
      run_pixels_left = cnt;
      byte_slot = '0;
      pixel_acc = '0;
      awaiting_header = 1'b0;
      return 1'b0;
    end
    pixel_acc |= PIX_W'(b) << (8 * byte_slot);
    byte_slot = byte_slot + 2'd1;
    bpp_eff = (set_bpp < BPP_MIN) ? BPP_MIN : (set_bpp > BPP_MAX) ? BPP_MAX : set_bpp;
    if (byte_slot != '0 && BPP_W'(byte_slot) < bpp_eff) return 1'b0;
    if (run_is_repeat) begin
      cnt = run_pixels_left;
      run_pixels_left = '0;
    end else begin
      cnt = 8'd1;
      if (run_pixels_left != '0) run_pixels_left = run_pixels_left - 8'd1;
    end
    image_pixels = image_pixels + TOTAL_W'(cnt);
    r.pixel = pixel_acc;
    r.count = cnt;
    r.done = (image_pixels >= total);
    pixel_acc = '0;
    byte_slot = '0;
    if (r.done) begin
      image_pixels = '0;
      run_pixels_left = '0;
    end
    if (run_pixels_left == '0) awaiting_header = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(MAX_DIMENSION, 32767));
    if (r == 2) return DIM_W'(MAX_DIMENSION);
    return DIM_W'($urandom_range(1, 6));
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input pixel_result_t want);
    pixel_result_t got;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (in_stall);
    if (decode_byte(b, got)) expected_pixels.push_back(typed ? want : got);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BPP:    set_bpp = data[BPP_W-1:0];
      REG_WIDTH:  set_width = data;
      REG_HEIGHT: set_height = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, let every expected pixel arrive, then let the block settle
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          stretch;
    bit          stalling;
    stretch = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stalling = !stalling;
          if (stalling) stretch = $urandom_range(1, 7);
          else stretch = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 80 : 10);
        end
        out_stall <= stalling;
        stretch--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected item: expected none, actual pixel %h count %0d done %0d",
                   $time, out_pixel_value, out_repeat_count, out_image_done);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_value !== want.pixel) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: pixel_value expected %h actual %h",
                     $time, want.pixel, out_pixel_value);
        end
        if (out_repeat_count !== want.count) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: repeat_count expected %0d actual %0d",
                     $time, want.count, out_repeat_count);
        end
        if (out_image_done !== want.done) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: image_done expected %0d actual %0d",
                     $time, want.done, out_image_done);
        end
      end
    end
  end

  initial begin
    int               random_left;
    int               phase_len;
    logic [DIM_W-1:0] data;
    logic [7:0]       b;
    int               r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_pipeline();
        write_reg(directed_rows[i].reg_index, directed_rows[i].data);
      end else begin
        send_byte(directed_rows[i].data[7:0], directed_rows[i].typed, directed_rows[i].want);
      end
    end

    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      drain_pipeline();
      if ($urandom_range(0, 9) < 7) begin
        data = DIM_W'($urandom);
        data[BPP_W-1:0] = ($urandom_range(0, 9) < 7) ? BPP_W'($urandom_range(2, 4))
                                                       : BPP_W'($urandom_range(0, 7));
        write_reg(REG_BPP, data);
      end
      if ($urandom_range(0, 9) < 7) write_reg(REG_WIDTH, pick_dim());
      if ($urandom_range(0, 9) < 7) write_reg(REG_HEIGHT, pick_dim());
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
      phase_len = $urandom_range(20, 120);
      for (int k = 0; k < phase_len && random_left > 0; k++) begin
        quiet = (random_left <= 150);
        r = $urandom_range(0, 99);
        if (r < 5 || !awaiting_header) begin
          // pixel byte, or an out-of-place byte as noise
          b = 8'($urandom);
        end else if (r < 65) begin
          b = {1'($urandom), 7'($urandom_range(0, 7))};
        end else if (r < 90) begin
          b = 8'($urandom);
        end else begin
          b = {1'($urandom), 7'h7f};
        end
        send_byte(b, 1'b0, '0);
        random_left--;
      end
    end

    drain_pipeline();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/tga_rle_pkg.sv
rtl/tga_rle_packet_decoder.sv
rtl/tga_rle_checker.sv
dv/tb.sv
